### rtl/lrev_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lrev_pkg;

    localparam int unsigned CHAR_W = 8;
    localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_EMIT,
        ST_SPACE
    } seq_state_t;

    // One result handed from the sequencer to the output register
    typedef struct packed {
        logic              load;
        logic [CHAR_W-1:0] data;
        logic              last_byte;
        logic              ovf;
    } res_load_t;

endpackage

`default_nettype wire

### rtl/lrev_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lrev_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       end_of_text;

    modport source (output valid, output in_char, output end_of_text, input ready);
    modport sink (input valid, input in_char, input end_of_text, output ready);
endinterface

interface lrev_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       final_out;
    logic       overflowed;

    modport source (output valid, output out_char, output final_out, output overflowed,
                    input ready);
    modport sink (input valid, input out_char, input final_out, input overflowed,
                  output ready);
endinterface

interface lrev_cfg_if;
    logic valid;
    logic ready;
    logic reverse_mode;

    modport source (output valid, output reverse_mode, input ready);
    modport sink (input valid, input reverse_mode, output ready);
endinterface

`default_nettype wire

### rtl/lrev_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module lrev_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // Hold read data until the next read
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/lrev_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module lrev_seq #(
    parameter int unsigned STACK_DEPTH = 32,
    parameter int unsigned CW = $clog2(STACK_DEPTH + 1),
    parameter int unsigned AW = $clog2(STACK_DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic [7:0]        in_char,
    input  wire logic              end_of_text,
    input  wire logic              mode,
    input  wire logic              out_free,
    input  wire logic [7:0]        rd_data,
    output logic                   in_ready,
    output logic                   wr_en,
    output logic      [AW-1:0]     wr_addr,
    output logic                   rd_en,
    output logic      [AW-1:0]     rd_addr,
    output lrev_pkg::res_load_t    res
);

    lrev_pkg::seq_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic          last_reg, last_next;
    logic          space_reg, space_next;
    logic          tag_final_reg, tag_final_next;

    // Shared up/down counter adder
    logic          dec;
    logic [CW-1:0] cnt_sum;
    logic          is_space;
    logic          do_push;
    logic          do_drain;

    assign cnt_sum  = count_reg + (dec ? {CW{1'b1}} : CW'(1));
    assign is_space = (in_char == lrev_pkg::SPACE_CHAR);
    assign do_push  = !mode || !is_space;
    assign do_drain = end_of_text || (mode && is_space);
    assign wr_addr  = count_reg[AW-1:0];
    assign rd_addr  = cnt_sum[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lrev_pkg::ST_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            last_reg      <= 1'b0;
            space_reg     <= 1'b0;
            tag_final_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            last_reg      <= last_next;
            space_reg     <= space_next;
            tag_final_reg <= tag_final_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        last_next      = last_reg;
        space_next     = space_reg;
        tag_final_next = tag_final_reg;
        dec            = 1'b0;
        in_ready       = 1'b0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        res            = '0;

        case (state_reg)
            lrev_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (do_push)
                    begin
                        if (count_reg < CW'(STACK_DEPTH))
                        begin
                            wr_en      = 1'b1;
                            count_next = cnt_sum;
                        end
                        else
                        begin
                            // Drop the byte, remember it for the final result
                            ovf_next = 1'b1;
                        end
                    end
                    last_next  = end_of_text;
                    space_next = mode && is_space;
                    if (do_drain)
                    begin
                        state_next = lrev_pkg::ST_DRAIN;
                    end
                end
            end

            lrev_pkg::ST_DRAIN:
            begin
                if (count_reg == '0)
                begin
                    state_next = space_reg ? lrev_pkg::ST_SPACE : lrev_pkg::ST_IDLE;
                end
                else
                begin
                    dec            = 1'b1;
                    rd_en          = 1'b1;
                    count_next     = cnt_sum;
                    tag_final_next = last_reg && !space_reg && (count_reg == CW'(1));
                    state_next     = lrev_pkg::ST_EMIT;
                end
            end

            lrev_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    res.load      = 1'b1;
                    res.data      = rd_data;
                    res.last_byte = tag_final_reg;
                    res.ovf       = tag_final_reg && ovf_reg;
                    if (tag_final_reg)
                    begin
                        ovf_next = 1'b0;
                    end
                    state_next = lrev_pkg::ST_DRAIN;
                end
            end

            lrev_pkg::ST_SPACE:
            begin
                if (out_free)
                begin
                    res.load      = 1'b1;
                    res.data      = lrev_pkg::SPACE_CHAR;
                    res.last_byte = last_reg;
                    res.ovf       = last_reg && ovf_reg;
                    if (last_reg)
                    begin
                        ovf_next = 1'b0;
                    end
                    state_next = lrev_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = lrev_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/lifo_text_and_word_reverser_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Byte-stream reverser built around a LIFO of STACK_DEPTH bytes held in a
// single-port-write, registered-read RAM. reverse_mode 0 reverses a whole
// text (ended by end_of_text); mode 1 reverses each space-separated word and
// passes spaces through. A byte that is pushed without a drain leaves the
// block idle, so the next request is accepted in the following cycle. A byte
// that starts a drain holds off requests until the stack is empty and any
// passed space is out: each stacked byte is read from the RAM in ST_DRAIN and
// loaded into the output register in ST_EMIT, which waits while the output
// is stalled. Bytes pushed onto a full stack are dropped; overflowed is
// raised on the text's final result (final_out) and then cleared.
module lifo_text_and_word_reverser_core #(
    parameter int unsigned STACK_DEPTH = 32
) (
    input wire logic   clk,
    input wire logic   rst_n,
    lrev_in_if.sink    in_req,
    lrev_out_if.source out_res,
    lrev_cfg_if.sink   cfg
);

    localparam int unsigned AW = $clog2(STACK_DEPTH);

    logic                mode_reg;
    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_char_reg;
    logic                final_reg;
    logic                ovf_reg;
    logic                out_free;
    logic                wr_en;
    logic                rd_en;
    logic [AW-1:0]       wr_addr;
    logic [AW-1:0]       rd_addr;
    logic [7:0]          rd_data;
    lrev_pkg::res_load_t res;

    assign cfg.ready          = 1'b1;
    assign out_free           = !out_valid_reg || out_res.ready;
    assign out_res.valid      = out_valid_reg;
    assign out_res.out_char   = out_char_reg;
    assign out_res.final_out  = final_reg;
    assign out_res.overflowed = ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            mode_reg <= cfg.reverse_mode;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.load)
        begin
            out_char_reg <= res.data;
            final_reg    <= res.last_byte;
            ovf_reg      <= res.ovf;
        end
    end

    lrev_seq #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_req.valid),
        .in_char     (in_req.in_char),
        .end_of_text (in_req.end_of_text),
        .mode        (mode_reg),
        .out_free    (out_free),
        .rd_data     (rd_data),
        .in_ready    (in_req.ready),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .res         (res)
    );

    lrev_ram #(
        .WIDTH (8),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (in_req.in_char),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

`default_nettype wire

### rtl/lrev_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module lrev_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       end_of_text,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_char,
    input wire logic       final_out,
    input wire logic       overflowed
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_char) && $stable(final_out)
                                    && $stable(overflowed))
        else $error("result payload changed while stalled");

    // Overflow is only reported on the text's final result
    a_ovf_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !overflowed || final_out)
        else $error("overflowed set on a result that is not final");

    // The final byte always starts a drain, so the next request waits
    a_eot_drain: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && end_of_text |=> !in_ready)
        else $error("request accepted right after a final byte");

endmodule

bind lifo_text_and_word_reverser_core lrev_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_req.valid),
    .in_ready    (in_req.ready),
    .end_of_text (in_req.end_of_text),
    .out_valid   (out_res.valid),
    .out_ready   (out_res.ready),
    .out_char    (out_res.out_char),
    .final_out   (out_res.final_out),
    .overflowed  (out_res.overflowed)
);

`default_nettype wire

### tb/sv/tb_lifo_text_and_word_reverser_core.sv
`timescale 1ns / 1ps

module tb_lifo_text_and_word_reverser_core;

    localparam int unsigned STACK_DEPTH = 32;
    localparam int unsigned DRAIN_SLACK = 8;
    localparam logic MODE_TEXT = 1'b0;
    localparam logic MODE_WORD = 1'b1;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
        logic       ovf;
    } rev_byte_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] ch;
        logic       eot;
        logic       typed;
        rev_byte_t  want;
    } dir_row_t;

    localparam rev_byte_t NO_WANT = '0;
    localparam int DIR_ROWS = 22;

    // Typed rows are single-byte texts on an empty stack; all others use the predictor
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{MODE_TEXT, 8'h41, 1'b1, 1'b1, '{8'h41, 1'b1, 1'b0}},
        '{MODE_TEXT, 8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b0}},
        '{MODE_TEXT, 8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b0}},
        '{MODE_TEXT, 8'h61, 1'b0, 1'b0, NO_WANT},
        '{MODE_TEXT, 8'h62, 1'b0, 1'b0, NO_WANT},
        '{MODE_TEXT, lrev_pkg::SPACE_CHAR, 1'b1, 1'b0, NO_WANT},
        '{MODE_TEXT, 8'h70, 1'b0, 1'b0, NO_WANT},
        '{MODE_TEXT, 8'h71, 1'b0, 1'b0, NO_WANT},
        '{MODE_WORD, lrev_pkg::SPACE_CHAR, 1'b0, 1'b0, NO_WANT},
        '{MODE_WORD, 8'h72, 1'b1, 1'b0, NO_WANT},
        '{MODE_WORD, lrev_pkg::SPACE_CHAR, 1'b1, 1'b1, '{lrev_pkg::SPACE_CHAR, 1'b1, 1'b0}},
        '{MODE_WORD, 8'h78, 1'b0, 1'b0, NO_WANT},
        '{MODE_WORD, 8'h79, 1'b0, 1'b0, NO_WANT},
        '{MODE_WORD, lrev_pkg::SPACE_CHAR, 1'b0, 1'b0, NO_WANT},
        '{MODE_WORD, 8'h7A, 1'b1, 1'b0, NO_WANT},
        '{MODE_WORD, lrev_pkg::SPACE_CHAR, 1'b0, 1'b0, NO_WANT},
        '{MODE_WORD, lrev_pkg::SPACE_CHAR, 1'b1, 1'b0, NO_WANT},
        '{MODE_WORD, 8'h00, 1'b0, 1'b0, NO_WANT},
        '{MODE_WORD, 8'hFF, 1'b1, 1'b0, NO_WANT},
        '{MODE_WORD, 8'h6B, 1'b0, 1'b0, NO_WANT},
        '{MODE_WORD, lrev_pkg::SPACE_CHAR, 1'b1, 1'b0, NO_WANT},
        '{MODE_TEXT, lrev_pkg::SPACE_CHAR, 1'b1, 1'b1, '{lrev_pkg::SPACE_CHAR, 1'b1, 1'b0}}
    };

    logic clk;
    logic rst_n;

    lrev_in_if  req_if ();
    lrev_out_if res_if ();
    lrev_cfg_if cfg_if ();

    lifo_text_and_word_reverser_core #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_req(req_if.sink),
        .out_res(res_if.source),
        .cfg(cfg_if.sink)
    );

    // Predictor state
    logic [7:0] lifo_mem [STACK_DEPTH];
    int unsigned lifo_fill;
    logic ovf_sticky;
    logic word_mode;

    rev_byte_t reversed_q [$];

    int send_idle_pct;
    int recv_idle_pct;
    int stall_left;
    int mismatches;
    int bytes_sent;
    int texts_sent;
    int bytes_checked;
    int ovf_texts;
    int word_texts;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    task automatic push_lifo(input logic [7:0] ch);
        if (lifo_fill >= STACK_DEPTH)
            ovf_sticky = 1'b1;
        else
        begin
            lifo_mem[lifo_fill] = ch;
            lifo_fill++;
        end
    endtask

    task automatic drain_lifo();
        while (lifo_fill > 0)
        begin
            lifo_fill--;
            reversed_q.push_back('{lifo_mem[lifo_fill], 1'b0, 1'b0});
        end
    endtask

    task automatic reverse_step(input logic [7:0] ch, input logic eot);
        int base;
        base = reversed_q.size();
        if (word_mode == MODE_TEXT || ch != lrev_pkg::SPACE_CHAR)
        begin
            push_lifo(ch);
            if (eot)
                drain_lifo();
        end
        else
        begin
            drain_lifo();
            reversed_q.push_back('{ch, 1'b0, 1'b0});
        end
        if (eot)
        begin
            if (reversed_q.size() > base)
            begin
                reversed_q[reversed_q.size() - 1].fin = 1'b1;
                reversed_q[reversed_q.size() - 1].ovf = ovf_sticky;
            end
            ovf_sticky = 1'b0;
        end
    endtask

    // Receiver: random back-pressure, or a forced hold while stall_left runs down
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            res_if.ready = 1'b0;
            stall_left--;
        end
        else
            res_if.ready = ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (reversed_q.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual %h/%b/%b", $time,
                         res_if.out_char, res_if.final_out, res_if.overflowed);
                mismatches++;
            end
            else
            begin
                rev_byte_t want;
                want = reversed_q.pop_front();
                if (res_if.out_char !== want.ch)
                begin
                    $display("%0t: out_char expected %h, actual %h", $time, want.ch,
                             res_if.out_char);
                    mismatches++;
                end
                if (res_if.final_out !== want.fin)
                begin
                    $display("%0t: final_out expected %b, actual %b", $time, want.fin,
                             res_if.final_out);
                    mismatches++;
                end
                if (res_if.overflowed !== want.ovf)
                begin
                    $display("%0t: overflowed expected %b, actual %b", $time, want.ovf,
                             res_if.overflowed);
                    mismatches++;
                end
                if (want.fin && want.ovf)
                    ovf_texts++;
                bytes_checked++;
            end
        end
    end

    // Hold until every expected byte is out, then let the block settle
    task automatic wait_idle();
        req_if.valid = 1'b0;
        while (reversed_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_SLACK) @(negedge clk);
    endtask

    task automatic write_mode(input logic mode);
        wait_idle();
        cfg_if.valid = 1'b1;
        cfg_if.reverse_mode = mode;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        word_mode = mode;
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    // Called at a falling edge; returns at a falling edge with valid low
    task automatic send_byte(input logic [7:0] ch, input logic eot, input logic typed,
                             input rev_byte_t want);
        int base;
        while ($urandom_range(99) < send_idle_pct)
            @(negedge clk);
        req_if.valid = 1'b1;
        req_if.in_char = ch;
        req_if.end_of_text = eot;
        do
            @(posedge clk);
        while (!req_if.ready);
        base = reversed_q.size();
        reverse_step(ch, eot);
        if (typed)
        begin
            while (reversed_q.size() > base)
                void'(reversed_q.pop_back());
            reversed_q.push_back(want);
        end
        bytes_sent++;
        if (eot)
        begin
            texts_sent++;
            if (word_mode == MODE_WORD)
                word_texts++;
        end
        @(negedge clk);
        req_if.valid = 1'b0;
    endtask

    task automatic send_text(input int len);
        logic [7:0] ch;
        int pick;
        if ($urandom_range(99) < 30)
            write_mode(1'($urandom_range(1)));
        for (int i = 0; i < len; i++)
        begin
            // Occasionally switch mode partway through a text
            if ($urandom_range(99) < 3)
                write_mode(1'($urandom_range(1)));
            pick = $urandom_range(99);
            if (pick < 20)
                ch = lrev_pkg::SPACE_CHAR;
            else if (pick < 25)
                ch = $urandom_range(1) ? 8'hFF : 8'h00;
            else
                ch = 8'($urandom_range(255));
            send_byte(ch, i == len - 1, 1'b0, NO_WANT);
        end
    endtask

    task automatic run_random(input int n_bytes);
        int stop_at;
        int len;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
        begin
            if ($urandom_range(99) < 8)
                len = $urandom_range(STACK_DEPTH + 8, STACK_DEPTH + 1);
            else
                len = $urandom_range(8, 1);
            send_text(len);
        end
    endtask

    initial
    begin
        req_if.valid = 1'b0;
        req_if.in_char = '0;
        req_if.end_of_text = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.reverse_mode = MODE_TEXT;
        res_if.ready = 1'b0;
        stall_left = 0;
        mismatches = 0;
        bytes_sent = 0;
        texts_sent = 0;
        bytes_checked = 0;
        ovf_texts = 0;
        word_texts = 0;
        lifo_fill = 0;
        ovf_sticky = 1'b0;
        word_mode = MODE_TEXT;
        foreach (lifo_mem[i])
            lifo_mem[i] = '0;
        send_idle_pct = 28;
        recv_idle_pct = 58;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_rows[i].mode != word_mode)
                write_mode(dir_rows[i].mode);
            send_byte(dir_rows[i].ch, dir_rows[i].eot, dir_rows[i].typed, dir_rows[i].want);
        end

        run_random(130);
        send_idle_pct = 58;
        recv_idle_pct = 28;
        run_random(130);
        send_idle_pct = 0;
        recv_idle_pct = 0;

        // Hold the output long enough that the stack fills and input stalls
        write_mode(MODE_TEXT);
        stall_left = 400;
        for (int i = 0; i < STACK_DEPTH + 4; i++)
            send_byte(8'($urandom_range(255)), i == STACK_DEPTH + 3, 1'b0, NO_WANT);
        send_text(5);
        run_random(120);

        wait_idle();
        repeat (DRAIN_SLACK) @(posedge clk);
        $display("Sent %0d bytes in %0d texts (%0d ended in word mode), checked %0d results,",
                 bytes_sent, texts_sent, word_texts, bytes_checked);
        $display("%0d texts reported a full-stack drop.", ovf_texts);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
